FILE: hw/rtl/wain_pkg.sv
// ----------------------------------------------------------------------------
// wain_pkg: shared types and constants of the windowed accel integrator
// Field widths, register indexes, reset values and the lane control bundle.
// ----------------------------------------------------------------------------
package wain_pkg;

    localparam int NUM_LANES  = 3;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int GAIN_SHIFT = 16;
    localparam int CNT_W      = 8;
    localparam int IDX_W      = 32;

    // lane multiplier operand width covers a signed sum and an unsigned gain
    localparam int MUL_W      = 25;
    localparam int VEL_W      = 24;
    localparam int MEAN_W     = 17;
    localparam int MEANQ_W    = 16;
    localparam int VSQ_W      = 46;
    localparam int MSQ_W      = 31;

    // radicand widths of the two magnitude roots
    localparam int ASUM_W     = 32;
    localparam int VSUM_W     = 48;
    localparam int AMAG_W     = ASUM_W / 2;
    localparam int VMAG_W     = VSUM_W / 2;

    localparam int MAX_WINDOW = 255;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0]  WINDOW_SIZE_RST   = CNT_W'(5);
    localparam logic [GAIN_W-1:0] VELOCITY_GAIN_RST = GAIN_W'(6423);

    // lane multiplier operand select
    localparam logic [1:0] MUL_GAIN = 2'd0;
    localparam logic [1:0] MUL_VEL  = 2'd1;
    localparam logic [1:0] MUL_MEAN = 2'd2;

    typedef struct packed {
        logic       acc_en;
        logic       close;
        logic       mul_en;
        logic [1:0] mul_sel;
    } wain_lane_ctrl_t;

endpackage

FILE: hw/rtl/wain_lane.sv
// ----------------------------------------------------------------------------
// wain_lane: one axis of the integrator
// Window accumulator, gain multiply, mean divider and squares for one axis.
// ----------------------------------------------------------------------------
module wain_lane import wain_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  wain_lane_ctrl_t          ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [GAIN_W-1:0]        gain,
    input  logic [CNT_W-1:0]         div_n,
    output logic signed [VEL_W-1:0]  vel,
    output logic [VSQ_W-1:0]         vel_sq,
    output logic [MSQ_W-1:0]         mean_sq,
    output logic                     div_done
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   work_sum_reg;

    logic [SUM_W-1:0]          dvd_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic [CNT_W-1:0]          den_reg;
    logic                      neg_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [CNT_W:0]            rem_sh;
    logic                      q_bit;

    logic signed [MEAN_W-1:0]  mean;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] prod;

    logic signed [VEL_W-1:0]   vel_reg;
    logic [VSQ_W-1:0]          vsq_reg;
    logic [MSQ_W-1:0]          msq_reg;

    // saturating accumulate
    always_comb begin
        sum_wide = {sum_reg[SUM_W-1], sum_reg}
                 + {{(SUM_W+1-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctrl.acc_en) begin
            sum_reg <= ctrl.close ? '0 : sum_next;
        end
    end

    // restoring divider, one quotient bit per cycle; quotient shifts into dvd
    always_comb begin
        rem_sh = {rem_reg, dvd_reg[SUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (ctrl.acc_en && ctrl.close) begin
            step_reg <= STEP_W'(SUM_W);
        end else if (step_reg != '0) begin
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.acc_en && ctrl.close) begin
            work_sum_reg <= sum_next;
            neg_reg      <= sum_next[SUM_W-1];
            dvd_reg      <= sum_next[SUM_W-1] ? (~sum_next + SUM_W'(1)) : sum_next;
            rem_reg      <= '0;
            den_reg      <= div_n;
        end else if (step_reg != '0) begin
            rem_reg <= q_bit ? CNT_W'(rem_sh - {1'b0, den_reg}) : rem_sh[CNT_W-1:0];
            dvd_reg <= {dvd_reg[SUM_W-2:0], q_bit};
        end
    end

    assign div_done = (step_reg == '0);

    // truncated mean: magnitude never exceeds one full-scale sample
    assign mean = neg_reg ? -$signed({1'b0, dvd_reg[MEANQ_W-1:0]})
                          :  $signed({1'b0, dvd_reg[MEANQ_W-1:0]});

    // shared multiplier: gain product, velocity square, mean square
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.mul_sel)
            MUL_GAIN: begin
                mul_a = {work_sum_reg[SUM_W-1], work_sum_reg};
                mul_b = {{(MUL_W-GAIN_W){1'b0}}, gain};
            end
            MUL_VEL: begin
                mul_a = {{(MUL_W-VEL_W){vel_reg[VEL_W-1]}}, vel_reg};
                mul_b = mul_a;
            end
            MUL_MEAN: begin
                mul_a = {{(MUL_W-MEAN_W){mean[MEAN_W-1]}}, mean};
                mul_b = mul_a;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            unique case (ctrl.mul_sel)
                MUL_GAIN: vel_reg <= prod[GAIN_SHIFT+VEL_W-1:GAIN_SHIFT];
                MUL_VEL:  vsq_reg <= prod[VSQ_W-1:0];
                MUL_MEAN: msq_reg <= prod[MSQ_W-1:0];
                default:  vel_reg <= vel_reg;
            endcase
        end
    end

    assign vel     = vel_reg;
    assign vel_sq  = vsq_reg;
    assign mean_sq = msq_reg;

endmodule

FILE: hw/rtl/wain_isqrt.sv
// ----------------------------------------------------------------------------
// wain_isqrt: iterative floor square root
// Digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
module wain_isqrt import wain_pkg::*; #(
    parameter int W = VSUM_W
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   radicand,
    output logic           busy,
    output logic [W/2-1:0] root
);

    logic [W-1:0] v_reg;
    logic [W-1:0] res_reg;
    logic [W-1:0] bit_reg;
    logic [W:0]   trial;
    logic         take;

    always_comb begin
        trial = {1'b0, res_reg} + {1'b0, bit_reg};
        take  = ({1'b0, v_reg} >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= '0;
        end else if (start) begin
            bit_reg <= W'(1) << (W - 2);
        end else begin
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= radicand;
            res_reg <= '0;
        end else if (bit_reg != '0) begin
            if (take) begin
                v_reg   <= v_reg - trial[W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
        end
    end

    assign busy = (bit_reg != '0);
    assign root = res_reg[W/2-1:0];

endmodule

FILE: hw/rtl/wain_merge.sv
// ----------------------------------------------------------------------------
// wain_merge: combine the lanes into vector magnitudes
// Sums the per-axis squares and runs both floor roots side by side.
// ----------------------------------------------------------------------------
module wain_merge import wain_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MSQ_W-1:0]  acc_sq [NUM_LANES],
    input  logic [VSQ_W-1:0]  vel_sq [NUM_LANES],
    output logic              busy,
    output logic [AMAG_W-1:0] accel_mag,
    output logic [VMAG_W-1:0] vel_mag
);

    logic [ASUM_W-1:0] acc_rad;
    logic [VSUM_W-1:0] vel_rad;
    logic              acc_busy;
    logic              vel_busy;

    // three squares per vector; the totals always fit the radicand widths
    always_comb begin
        acc_rad = '0;
        vel_rad = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            acc_rad = acc_rad + ASUM_W'(acc_sq[i]);
            vel_rad = vel_rad + VSUM_W'(vel_sq[i]);
        end
    end

    wain_isqrt #(.W(ASUM_W)) u_acc_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .radicand (acc_rad),
        .busy     (acc_busy),
        .root     (accel_mag)
    );

    wain_isqrt #(.W(VSUM_W)) u_vel_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .radicand (vel_rad),
        .busy     (vel_busy),
        .root     (vel_mag)
    );

    assign busy = acc_busy | vel_busy;

endmodule

FILE: hw/rtl/windowed_accel_integrate_norm_unit.sv
// ----------------------------------------------------------------------------
// windowed_accel_integrate_norm_unit: windowed accel integrator, top level
// Sums three-axis accel samples over non-overlapping windows and, per window,
// reports per-axis velocity, mean-acceleration magnitude and velocity magnitude.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | beat contents
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_valid / s_ready  | s_accel_x, s_accel_y, s_accel_z
//  m_      | out | m_valid / m_ready  | m_window_index, m_vel_x/y/z,
//          |     |                    | m_accel_magnitude, m_vel_magnitude
//  cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wr_data (no read-back)
//
//  A sample that does not close its window is always accepted.
//  A closing sample starts the back end: gain multiply, velocity square and the
//  24-step mean divider per lane, mean square, then the 24-step velocity root;
//  m_valid rises once the roots finish, later while m_ is stalled.
//  Only the next closing sample is held off until the result reaches m_;
//  other samples keep accumulating. Reset (aresetn low) clears sums and counts.
//
module windowed_accel_integrate_norm_unit import wain_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wr_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [SAMPLE_W-1:0] s_accel_x,
    input  logic signed [SAMPLE_W-1:0] s_accel_y,
    input  logic signed [SAMPLE_W-1:0] s_accel_z,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [IDX_W-1:0]          m_window_index,
    output logic signed [VEL_W-1:0]   m_vel_x,
    output logic signed [VEL_W-1:0]   m_vel_y,
    output logic signed [VEL_W-1:0]   m_vel_z,
    output logic [AMAG_W-1:0]         m_accel_magnitude,
    output logic [VMAG_W-1:0]         m_vel_magnitude
);

    // back-end sequencer states
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] S_MUL   = 3'd1;
    localparam logic [ST_W-1:0] S_SQV   = 3'd2;
    localparam logic [ST_W-1:0] S_DIV   = 3'd3;
    localparam logic [ST_W-1:0] S_SQM   = 3'd4;
    localparam logic [ST_W-1:0] S_ROOT0 = 3'd5;
    localparam logic [ST_W-1:0] S_ROOT  = 3'd6;
    localparam logic [ST_W-1:0] S_OUT   = 3'd7;

    // configuration
    logic [CNT_W-1:0]  window_size_reg;
    logic [GAIN_W-1:0] velocity_gain_reg;

    // window bookkeeping
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  size_eff;
    logic [IDX_W-1:0]  windows_done_reg;
    logic              closing;
    logic              accept;

    logic [ST_W-1:0]   state_reg;
    logic [ST_W-1:0]   state_next;
    logic              out_load;

    wain_lane_ctrl_t   lane_ctrl;

    logic signed [SAMPLE_W-1:0] lane_sample [NUM_LANES];
    logic signed [VEL_W-1:0]    lane_vel    [NUM_LANES];
    logic [VSQ_W-1:0]           lane_vsq    [NUM_LANES];
    logic [MSQ_W-1:0]           lane_msq    [NUM_LANES];
    logic [NUM_LANES-1:0]       lane_div_done;

    logic              merge_start;
    logic              merge_busy;
    logic [AMAG_W-1:0] accel_mag;
    logic [VMAG_W-1:0] vel_mag;

    // output register
    logic                     m_valid_reg;
    logic [IDX_W-1:0]         m_index_reg;
    logic signed [VEL_W-1:0]  m_vel_reg [NUM_LANES];
    logic [AMAG_W-1:0]        m_amag_reg;
    logic [VMAG_W-1:0]        m_vmag_reg;

    // ---------------------------------------------------------------------
    // Configuration writes; an unknown index is dropped
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg   <= WINDOW_SIZE_RST;
            velocity_gain_reg <= VELOCITY_GAIN_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_WINDOW_SIZE) begin
                window_size_reg <= cfg_wr_data[CNT_W-1:0];
            end else if (cfg_index == REG_VELOCITY_GAIN) begin
                velocity_gain_reg <= cfg_wr_data[GAIN_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Window control: a zero size acts as one, large sizes clamp to the
    // maximum; the window closes once the count reaches or passes the size,
    // so a size lowered mid-window closes it at the next sample.
    // ---------------------------------------------------------------------
    always_comb begin
        if (window_size_reg == '0) begin
            size_eff = CNT_W'(1);
        end else if (32'(window_size_reg) > MAX_WINDOW) begin
            size_eff = CNT_W'(MAX_WINDOW);
        end else begin
            size_eff = window_size_reg;
        end
        cnt_inc = cnt_reg + CNT_W'(1);
        closing = (cnt_inc >= size_eff);
    end

    // hold off only a closing sample while the back end is still busy
    assign s_ready = !(closing && (state_reg != S_IDLE));
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg          <= '0;
            windows_done_reg <= '0;
        end else if (accept) begin
            if (closing) begin
                cnt_reg          <= '0;
                windows_done_reg <= windows_done_reg + IDX_W'(1);
            end else begin
                cnt_reg <= cnt_inc;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Back-end sequencer
    // ---------------------------------------------------------------------
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept && closing) state_next = S_MUL;
            S_MUL:   state_next = S_SQV;
            S_SQV:   state_next = S_DIV;
            S_DIV:   if (&lane_div_done) state_next = S_SQM;
            S_SQM:   state_next = S_ROOT0;
            S_ROOT0: state_next = S_ROOT;
            S_ROOT:  if (!merge_busy) state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        lane_ctrl.acc_en  = accept;
        lane_ctrl.close   = accept && closing;
        lane_ctrl.mul_en  = (state_reg == S_MUL) || (state_reg == S_SQV)
                         || (state_reg == S_SQM);
        unique case (state_reg)
            S_SQV:   lane_ctrl.mul_sel = MUL_VEL;
            S_SQM:   lane_ctrl.mul_sel = MUL_MEAN;
            default: lane_ctrl.mul_sel = MUL_GAIN;
        endcase
    end

    assign merge_start = (state_reg == S_ROOT0);

    // ---------------------------------------------------------------------
    // Axis lanes and magnitude merge
    // ---------------------------------------------------------------------
    assign lane_sample[0] = s_accel_x;
    assign lane_sample[1] = s_accel_y;
    assign lane_sample[2] = s_accel_z;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        wain_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (lane_ctrl),
            .sample   (lane_sample[g]),
            .gain     (velocity_gain_reg),
            .div_n    (cnt_inc),
            .vel      (lane_vel[g]),
            .vel_sq   (lane_vsq[g]),
            .mean_sq  (lane_msq[g]),
            .div_done (lane_div_done[g])
        );
    end

    wain_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (merge_start),
        .acc_sq    (lane_msq),
        .vel_sq    (lane_vsq),
        .busy      (merge_busy),
        .accel_mag (accel_mag),
        .vel_mag   (vel_mag)
    );

    // ---------------------------------------------------------------------
    // Result register: load when free or being drained, drop valid on take
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_index_reg <= windows_done_reg;
            m_vel_reg   <= lane_vel;
            m_amag_reg  <= accel_mag;
            m_vmag_reg  <= vel_mag;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_window_index    = m_index_reg;
    assign m_vel_x           = m_vel_reg[0];
    assign m_vel_y           = m_vel_reg[1];
    assign m_vel_z           = m_vel_reg[2];
    assign m_accel_magnitude = m_amag_reg;
    assign m_vel_magnitude   = m_vmag_reg;

endmodule

FILE: verif/tb_windowed_accel_integrate_norm_unit.sv
// ----------------------------------------------------------------------------
// tb_windowed_accel_integrate_norm_unit: self-checking bench of the integrator
// Feeds three-axis accel samples, mirrors the window sums in a local model and
// compares every result beat field by field under varied handshake pressure.
// ----------------------------------------------------------------------------
module tb_windowed_accel_integrate_norm_unit;
    import wain_pkg::*;

    localparam int     CLK_PERIOD     = 8;
    localparam longint TIMEOUT_CYCLES = 2_000_000;
    // margin for the back end to drain before config
    localparam int     DRAIN_CYCLES   = 80;
    localparam int     RANDOM_ITEMS   = 1950;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam longint SUM_HI = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) << (SUM_W - 1));

    typedef enum int {FILL_RANDOM, FILL_HIGH, FILL_LOW} sample_fill_t;

    typedef struct {
        logic [IDX_W-1:0]        window_index;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_z;
        logic [AMAG_W-1:0]       accel_magnitude;
        logic [VMAG_W-1:0]       vel_magnitude;
    } window_result_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_accel_x;
    logic signed [SAMPLE_W-1:0] s_accel_y;
    logic signed [SAMPLE_W-1:0] s_accel_z;
    logic                       m_valid;
    logic                       m_ready;
    logic [IDX_W-1:0]           m_window_index;
    logic signed [VEL_W-1:0]    m_vel_x;
    logic signed [VEL_W-1:0]    m_vel_y;
    logic signed [VEL_W-1:0]    m_vel_z;
    logic [AMAG_W-1:0]          m_accel_magnitude;
    logic [VMAG_W-1:0]          m_vel_magnitude;

    // local copy of the block's registers and window state
    logic [CNT_W-1:0]  cfg_window_size   = WINDOW_SIZE_RST;
    logic [GAIN_W-1:0] cfg_velocity_gain = VELOCITY_GAIN_RST;
    int                win_sum_x = 0;
    int                win_sum_y = 0;
    int                win_sum_z = 0;
    logic [CNT_W-1:0]  win_fill = '0;
    logic [IDX_W-1:0]  windows_closed = '0;

    window_result_t    pending_windows[$];

    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int mismatch_count   = 0;
    int samples_sent     = 0;
    int windows_checked  = 0;
    int settings_applied = 0;

    windowed_accel_integrate_norm_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_accel_x         (s_accel_x),
        .s_accel_y         (s_accel_y),
        .s_accel_z         (s_accel_z),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_window_index    (m_window_index),
        .m_vel_x           (m_vel_x),
        .m_vel_y           (m_vel_y),
        .m_vel_z           (m_vel_z),
        .m_accel_magnitude (m_accel_magnitude),
        .m_vel_magnitude   (m_vel_magnitude)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Window model
    // ------------------------------------------------------------------

    // sums saturate at the 24-bit signed limits (never reached with 255 samples)
    function automatic int clamp_sum(input longint s);
        if (s > SUM_HI) return int'(SUM_HI);
        if (s < SUM_LO) return int'(SUM_LO);
        return int'(s);
    endfunction

    // Q0.16 gain; arithmetic shift rounds toward minus infinity
    function automatic longint scale_velocity(input int s);
        longint p;
        p = longint'(s) * longint'(cfg_velocity_gain);
        return p >>> GAIN_SHIFT;
    endfunction

    // floor square root, one result bit at a time from the top
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    // add one accepted sample; queue the window result when it closes
    function automatic void integrate_sample(input logic signed [SAMPLE_W-1:0] ax,
                                             input logic signed [SAMPLE_W-1:0] ay,
                                             input logic signed [SAMPLE_W-1:0] az);
        int             limit;
        int             n;
        longint         vx, vy, vz, mx, my, mz;
        window_result_t r;
        limit = int'(cfg_window_size);
        if (limit < 1) limit = 1;
        if (limit > MAX_WINDOW) limit = MAX_WINDOW;
        win_sum_x = clamp_sum(longint'(win_sum_x) + longint'(ax));
        win_sum_y = clamp_sum(longint'(win_sum_y) + longint'(ay));
        win_sum_z = clamp_sum(longint'(win_sum_z) + longint'(az));
        win_fill  = win_fill + 1'b1;
        // close at the first sample where the count reaches or passes the size
        if (win_fill != 0 && int'(win_fill) < limit) return;
        n  = (win_fill == 0) ? 256 : int'(win_fill);
        vx = scale_velocity(win_sum_x);
        vy = scale_velocity(win_sum_y);
        vz = scale_velocity(win_sum_z);
        mx = longint'(win_sum_x / n);
        my = longint'(win_sum_y / n);
        mz = longint'(win_sum_z / n);
        windows_closed    = windows_closed + 1'b1;
        r.window_index    = windows_closed;
        r.vel_x           = VEL_W'(vx);
        r.vel_y           = VEL_W'(vy);
        r.vel_z           = VEL_W'(vz);
        r.accel_magnitude = AMAG_W'(floor_root(longint'(mx * mx + my * my + mz * mz)));
        r.vel_magnitude   = VMAG_W'(floor_root(longint'(vx * vx + vy * vy + vz * vz)));
        pending_windows.push_back(r);
        win_sum_x = 0;
        win_sum_y = 0;
        win_sum_z = 0;
        win_fill  = '0;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall at random, check every beat against the model
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : result_checker
        window_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_windows.size() == 0) begin
                $error("result beat with no window pending: window_index %0d",
                       m_window_index);
                mismatch_count++;
            end else begin
                want = pending_windows.pop_front();
                check_field("window_index",    want.window_index,    m_window_index);
                check_field("vel_x",           want.vel_x,           m_vel_x);
                check_field("vel_y",           want.vel_y,           m_vel_y);
                check_field("vel_z",           want.vel_z,           m_vel_z);
                check_field("accel_magnitude", want.accel_magnitude, m_accel_magnitude);
                check_field("vel_magnitude",   want.vel_magnitude,   m_vel_magnitude);
            end
            windows_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Sample side and register writes
    // ------------------------------------------------------------------

    // Hold valid and payload until the beat is taken. Valid stays high after
    // acceptance; the next call replaces or drops the beat, settle_block drops it.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] ax,
                               input logic signed [SAMPLE_W-1:0] ay,
                               input logic signed [SAMPLE_W-1:0] az);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_accel_x <= ax;
        s_accel_y <= ay;
        s_accel_z <= az;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        integrate_sample(ax, ay, az);
        samples_sent++;
    endtask

    // drop valid, wait for every pending window, then let the back end drain
    task automatic settle_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_windows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            REG_WINDOW_SIZE:   cfg_window_size   = data[CNT_W-1:0];
            REG_VELOCITY_GAIN: cfg_velocity_gain = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // idle the block, hit an unmapped index, then load both registers
    task automatic set_config(input logic [CFG_DATA_W-1:0] size_word,
                              input logic [CFG_DATA_W-1:0] gain_word);
        logic [CFG_IDX_W-1:0] stray_index;
        stray_index = CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1,
                                                int'(REG_VELOCITY_GAIN) + 1));
        settle_block();
        write_reg(stray_index, CFG_DATA_W'($urandom));
        write_reg(REG_WINDOW_SIZE, size_word);
        write_reg(REG_VELOCITY_GAIN, gain_word);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_applied++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample(input sample_fill_t fill);
        int roll;
        roll = $urandom_range(15, 0);
        if (fill == FILL_HIGH || (fill == FILL_RANDOM && roll == 0)) return SAMPLE_MAX;
        if (fill == FILL_LOW || (fill == FILL_RANDOM && roll == 1)) return SAMPLE_MIN;
        return SAMPLE_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset values: size 5, default gain; full-scale samples on every axis
    task automatic test_default_window();
        send_sample(SAMPLE_MAX, SAMPLE_MIN, 16'sd0);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, 16'sd1);
        send_sample(-16'sd1, 16'sd1, SAMPLE_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        send_sample(16'sh5555, 16'shAAAA, -16'sd2);
    endtask

    // a size of zero closes every sample; gain at both ends
    task automatic test_zero_size_and_gain_extremes();
        set_config(CFG_DATA_W'(0), {CFG_DATA_W{1'b1}});
        send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        // small negative sum: floor of the scaled value must round down
        send_sample(-16'sd1, 16'sd0, 16'sd1);
        set_config(CFG_DATA_W'(1), CFG_DATA_W'(0));
        send_sample(SAMPLE_MAX, SAMPLE_MIN, 16'sd123);
    endtask

    // upper byte of the size word must be dropped
    task automatic test_register_decode();
        set_config({8'hA5, 8'd3}, VELOCITY_GAIN_RST);
        send_sample(16'sd1, 16'sd2, 16'sd3);
        send_sample(-16'sd4, -16'sd5, -16'sd6);
        send_sample(16'sd100, -16'sd100, 16'sd7);
    endtask

    // shrink the size below the fill: next sample closes, mean over all seven
    task automatic test_resize_mid_window();
        set_config(CFG_DATA_W'(10), VELOCITY_GAIN_RST);
        repeat (6) send_sample(draw_sample(FILL_RANDOM), draw_sample(FILL_RANDOM),
                               draw_sample(FILL_RANDOM));
        set_config(CFG_DATA_W'(4), CFG_DATA_W'(16'h8000));
        send_sample(draw_sample(FILL_RANDOM), draw_sample(FILL_RANDOM),
                    draw_sample(FILL_RANDOM));
    endtask

    // phases of random settings and pressure; partial windows carry over
    task automatic test_random_windows();
        int                phase;
        int                sent;
        int                eff;
        int                n_items;
        int                roll;
        logic [CNT_W-1:0]  size;
        logic [GAIN_W-1:0] gain;
        sample_fill_t      fill;
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                default: begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            if (phase < 2) begin
                // largest window at full gain with pinned samples: extreme sums
                size = CNT_W'(MAX_WINDOW);
                gain = {GAIN_W{1'b1}};
                fill = (phase == 0) ? FILL_HIGH : FILL_LOW;
            end else begin
                roll = $urandom_range(9, 0);
                case (roll)
                    0:       size = CNT_W'(MAX_WINDOW);
                    1:       size = '0;
                    2:       size = CNT_W'($urandom_range(MAX_WINDOW - 1, 9));
                    default: size = CNT_W'($urandom_range(8, 1));
                endcase
                roll = $urandom_range(5, 0);
                case (roll)
                    0:       gain = '0;
                    1:       gain = {GAIN_W{1'b1}};
                    2:       gain = VELOCITY_GAIN_RST;
                    default: gain = GAIN_W'($urandom);
                endcase
                roll = $urandom_range(7, 0);
                fill = (roll == 0) ? FILL_HIGH : (roll == 1) ? FILL_LOW : FILL_RANDOM;
            end
            set_config({CNT_W'($urandom), size}, gain);
            eff = (size == 0) ? 1 : int'(size);
            if (phase < 2)
                n_items = eff;
            else if (eff > 16)
                n_items = eff + $urandom_range(eff, 0);
            else
                n_items = $urandom_range(90, 30);
            // stop at the item budget
            if (n_items > RANDOM_ITEMS - sent) n_items = RANDOM_ITEMS - sent;
            repeat (n_items) begin
                send_sample(draw_sample(fill), draw_sample(fill), draw_sample(fill));
                sent++;
            end
            phase++;
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_accel_x   = '0;
        s_accel_y   = '0;
        s_accel_z   = '0;
        m_ready     = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_window();
        test_zero_size_and_gain_extremes();
        test_register_decode();
        test_resize_mid_window();
        test_random_windows();

        settle_block();
        $display("Covered %0d samples and %0d window results across %0d register settings",
                 samples_sent, windows_checked, settings_applied);
        $display("Window sizes 0..255, gains 0..65535, four handshake pressure modes");
        if (mismatch_count == 0 && pending_windows.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // hard stop if the handshake hangs
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("simulation failed");
        $finish;
    end

endmodule
